// ----- rtl/core/mtb_pkg.sv -----
// Package for the multitouch slot-to-report bridge: types, codes and microcode ROM.
package mtb_pkg;

  localparam int SLOTS = 4;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PC_W = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 18;
  localparam int PROD_W = 49;

  localparam logic [15:0] TYPE_SYN = 16'h0000;
  localparam logic [15:0] TYPE_ABS = 16'h0003;
  localparam logic [15:0] C_ABS_X = 16'h0000;
  localparam logic [15:0] C_ABS_Y = 16'h0001;
  localparam logic [15:0] C_SLOT = 16'h002f;
  localparam logic [15:0] C_TOUCH_MAJOR = 16'h0030;
  localparam logic [15:0] C_WIDTH_MAJOR = 16'h0032;
  localparam logic [15:0] C_POS_X = 16'h0035;
  localparam logic [15:0] C_POS_Y = 16'h0036;
  localparam logic [15:0] C_TRACK_ID = 16'h0039;
  localparam logic [15:0] C_SYN_REPORT = 16'h0000;
  localparam logic [15:0] C_SYN_MT_REPORT = 16'h0002;

  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_INDEX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOUCH_SIZE = 2'd3;

  // microprogram addresses
  localparam logic [PC_W-1:0] ST_IDLE = 5'd0;
  localparam logic [PC_W-1:0] ST_DISPATCH = 5'd1;
  localparam logic [PC_W-1:0] ST_SET_SLOT = 5'd2;
  localparam logic [PC_W-1:0] ST_SET_DOWN = 5'd3;
  localparam logic [PC_W-1:0] ST_MUL = 5'd4;
  localparam logic [PC_W-1:0] ST_STORE_POS = 5'd5;
  localparam logic [PC_W-1:0] ST_SYNC = 5'd6;
  localparam logic [PC_W-1:0] ST_TEST = 5'd7;
  localparam logic [PC_W-1:0] ST_NEXT_K = 5'd16;
  localparam logic [PC_W-1:0] ST_ANY = 5'd17;
  localparam logic [PC_W-1:0] ST_REPORT = 5'd19;

  typedef struct packed {
    logic [15:0]        ev_type;
    logic [15:0]        ev_code;
    logic signed [31:0] ev_value;
  } ev_in_t;

  typedef struct packed {
    logic [15:0]        out_type;
    logic [15:0]        out_code;
    logic signed [31:0] out_value;
    logic               last;
  } ev_out_t;

  typedef enum logic [3:0] {
    OP_WAIT_IN,
    OP_DISPATCH,
    OP_SET_SLOT,
    OP_SET_DOWN,
    OP_MUL,
    OP_STORE_POS,
    OP_CLR_K,
    OP_TEST,
    OP_EMIT,
    OP_NEXT_K,
    OP_ANY
  } op_e;

  typedef enum logic [2:0] {
    VS_ZERO,
    VS_X,
    VS_Y,
    VS_SIZE,
    VS_ID
  } vsel_e;

  typedef struct packed {
    op_e             op;
    logic            is_abs;
    logic [15:0]     code;
    vsel_e           vsel;
    logic            last;
    logic            jmp;
    logic [PC_W-1:0] target;
  } uword_t;

  function automatic uword_t mk(op_e op, logic is_abs, logic [15:0] code, vsel_e vsel,
                                logic last, logic jmp, logic [PC_W-1:0] target);
    uword_t w;
    w.op = op;
    w.is_abs = is_abs;
    w.code = code;
    w.vsel = vsel;
    w.last = last;
    w.jmp = jmp;
    w.target = target;
    return w;
  endfunction

  function automatic uword_t ucode(logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      5'd0:    w = mk(OP_WAIT_IN, 1'b0, C_SYN_REPORT, VS_ZERO, 1'b0, 1'b0, ST_IDLE);
      5'd1:    w = mk(OP_DISPATCH, 1'b0, C_SYN_REPORT, VS_ZERO, 1'b0, 1'b0, ST_IDLE);
      5'd2:    w = mk(OP_SET_SLOT, 1'b0, C_SYN_REPORT, VS_ZERO, 1'b0, 1'b1, ST_IDLE);
      5'd3:    w = mk(OP_SET_DOWN, 1'b0, C_SYN_REPORT, VS_ZERO, 1'b0, 1'b1, ST_IDLE);
      5'd4:    w = mk(OP_MUL, 1'b0, C_SYN_REPORT, VS_ZERO, 1'b0, 1'b0, ST_IDLE);
      5'd5:    w = mk(OP_STORE_POS, 1'b0, C_SYN_REPORT, VS_ZERO, 1'b0, 1'b1, ST_IDLE);
      5'd6:    w = mk(OP_CLR_K, 1'b0, C_SYN_REPORT, VS_ZERO, 1'b0, 1'b0, ST_IDLE);
      5'd7:    w = mk(OP_TEST, 1'b0, C_SYN_REPORT, VS_ZERO, 1'b0, 1'b0, ST_NEXT_K);
      5'd8:    w = mk(OP_EMIT, 1'b1, C_ABS_X, VS_X, 1'b0, 1'b0, ST_IDLE);
      5'd9:    w = mk(OP_EMIT, 1'b1, C_ABS_Y, VS_Y, 1'b0, 1'b0, ST_IDLE);
      5'd10:   w = mk(OP_EMIT, 1'b1, C_POS_X, VS_X, 1'b0, 1'b0, ST_IDLE);
      5'd11:   w = mk(OP_EMIT, 1'b1, C_POS_Y, VS_Y, 1'b0, 1'b0, ST_IDLE);
      5'd12:   w = mk(OP_EMIT, 1'b1, C_TOUCH_MAJOR, VS_SIZE, 1'b0, 1'b0, ST_IDLE);
      5'd13:   w = mk(OP_EMIT, 1'b1, C_WIDTH_MAJOR, VS_SIZE, 1'b0, 1'b0, ST_IDLE);
      5'd14:   w = mk(OP_EMIT, 1'b1, C_TRACK_ID, VS_ID, 1'b0, 1'b0, ST_IDLE);
      5'd15:   w = mk(OP_EMIT, 1'b0, C_SYN_MT_REPORT, VS_ZERO, 1'b0, 1'b0, ST_IDLE);
      5'd16:   w = mk(OP_NEXT_K, 1'b0, C_SYN_REPORT, VS_ZERO, 1'b0, 1'b0, ST_TEST);
      5'd17:   w = mk(OP_ANY, 1'b0, C_SYN_REPORT, VS_ZERO, 1'b0, 1'b0, ST_REPORT);
      5'd18:   w = mk(OP_EMIT, 1'b0, C_SYN_MT_REPORT, VS_ZERO, 1'b0, 1'b0, ST_IDLE);
      5'd19:   w = mk(OP_EMIT, 1'b0, C_SYN_REPORT, VS_ZERO, 1'b1, 1'b1, ST_IDLE);
      default: w = mk(OP_WAIT_IN, 1'b0, C_SYN_REPORT, VS_ZERO, 1'b0, 1'b1, ST_IDLE);
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/core/multitouch_slot_to_report_bridge_top.sv -----
// Top level of the multitouch slot-to-report bridge: microcoded sequencer and datapath.
//
//   channel  | signals                               | transfer when
//   ---------+---------------------------------------+-------------------------
//   in       | in_valid_i, in_ready_o, in_data_i     | in_valid_i & in_ready_o
//   out      | out_valid_o, out_ready_i, out_data_o  | out_valid_o & out_ready_i
//   cfg      | cfg_we_i, cfg_idx_i, cfg_wdata_i      | cfg_we_i
//
// One event at a time. Slot and tracking events set the current slot and its down
// flag, position events multiply, then clamp, and ignored events return to idle. A
// sync report emits eight reports per down slot, then SYN_MT_REPORT if no slot was
// down, then SYN_REPORT; a slot's reports go one per cycle while the output drains.
// Output stalls hold the sequencer on the emitting step. Reset clears the slot
// table and the control and config registers at once; no clearing pass.
module multitouch_slot_to_report_bridge_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  mtb_pkg::ev_in_t                      in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output mtb_pkg::ev_out_t                     out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [mtb_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [mtb_pkg::CFG_DATA_W-1:0]       cfg_wdata_i
);

  localparam logic [mtb_pkg::SLOT_W-1:0] LastSlot = mtb_pkg::SLOT_W'(mtb_pkg::SLOTS - 1);

  logic [2:0]  dev_q;
  logic [17:0] scale_x_q, scale_y_q;
  logic [7:0]  size_q;

  logic [mtb_pkg::PC_W-1:0]   pc_q, pc_d;
  logic [mtb_pkg::SLOT_W-1:0] cur_q, cur_d, k_q, k_d;
  logic                       any_q, any_d;
  logic [mtb_pkg::SLOTS-1:0]  down_q, down_d;
  logic [15:0]                fx_q [mtb_pkg::SLOTS];
  logic [15:0]                fy_q [mtb_pkg::SLOTS];
  logic                       pos_we;
  logic [15:0]                pos_val;

  mtb_pkg::ev_in_t  ev_q, ev_d;
  mtb_pkg::ev_out_t out_q, out_d;
  logic             out_valid_q, out_valid_d;
  logic [mtb_pkg::PROD_W-1:0] prod_q, prod_d;

  mtb_pkg::uword_t uw;
  logic            take;
  logic            is_abs_ev;
  logic [30:0]     raw;
  logic [17:0]     factor;
  logic [3:0]      id_base;
  logic [7:0]      track_id;
  logic [31:0]     value;

  assign uw = mtb_pkg::ucode(pc_q);
  assign is_abs_ev = (ev_q.ev_type == mtb_pkg::TYPE_ABS);
  assign raw = ev_q.ev_value[31] ? 31'd0 : ev_q.ev_value[30:0];
  assign factor = (ev_q.ev_code == mtb_pkg::C_POS_X) ? scale_x_q : scale_y_q;
  assign id_base = {dev_q, 1'b1};
  assign track_id = ({4'd0, id_base} << 3) + ({4'd0, id_base} << 1) + 8'(k_q);
  assign pos_val = (|prod_q[48:32]) ? 16'hffff : prod_q[31:16];

  always_comb begin
    case (uw.vsel)
      mtb_pkg::VS_X:    value = {16'd0, fx_q[k_q]};
      mtb_pkg::VS_Y:    value = {16'd0, fy_q[k_q]};
      mtb_pkg::VS_SIZE: value = {24'd0, size_q};
      mtb_pkg::VS_ID:   value = {24'd0, track_id};
      default:          value = 32'd0;
    endcase
  end

  always_comb begin
    pc_d = pc_q + 5'd1;
    take = uw.jmp;
    cur_d = cur_q;
    k_d = k_q;
    any_d = any_q;
    down_d = down_q;
    ev_d = ev_q;
    prod_d = prod_q;
    pos_we = 1'b0;
    out_d = out_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    in_ready_o = 1'b0;
    case (uw.op)
      mtb_pkg::OP_WAIT_IN: begin
        in_ready_o = 1'b1;
        ev_d = in_data_i;
        if (!in_valid_i) begin
          pc_d = pc_q;
        end
      end
      mtb_pkg::OP_DISPATCH: begin
        take = 1'b1;
        if (is_abs_ev && ev_q.ev_code == mtb_pkg::C_SLOT) begin
          pc_d = mtb_pkg::ST_SET_SLOT;
        end else if (is_abs_ev && ev_q.ev_code == mtb_pkg::C_TRACK_ID) begin
          pc_d = mtb_pkg::ST_SET_DOWN;
        end else if (is_abs_ev && (ev_q.ev_code == mtb_pkg::C_POS_X ||
                                   ev_q.ev_code == mtb_pkg::C_POS_Y)) begin
          pc_d = mtb_pkg::ST_MUL;
        end else if (ev_q.ev_type == mtb_pkg::TYPE_SYN &&
                     ev_q.ev_code == mtb_pkg::C_SYN_REPORT) begin
          pc_d = mtb_pkg::ST_SYNC;
        end else begin
          pc_d = mtb_pkg::ST_IDLE;
        end
      end
      mtb_pkg::OP_SET_SLOT: begin
        if (!ev_q.ev_value[31] && ev_q.ev_value[30:0] < 31'(mtb_pkg::SLOTS)) begin
          cur_d = ev_q.ev_value[mtb_pkg::SLOT_W-1:0];
        end
      end
      mtb_pkg::OP_SET_DOWN: begin
        down_d[cur_q] = ~(&ev_q.ev_value);
      end
      mtb_pkg::OP_MUL: begin
        prod_d = mtb_pkg::PROD_W'(raw * factor);
      end
      mtb_pkg::OP_STORE_POS: begin
        pos_we = 1'b1;
      end
      mtb_pkg::OP_CLR_K: begin
        k_d = '0;
        any_d = 1'b0;
      end
      mtb_pkg::OP_TEST: begin
        take = ~down_q[k_q];
        any_d = any_q | down_q[k_q];
      end
      mtb_pkg::OP_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.out_type = uw.is_abs ? mtb_pkg::TYPE_ABS : mtb_pkg::TYPE_SYN;
          out_d.out_code = uw.code;
          out_d.out_value = value;
          out_d.last = uw.last;
          out_valid_d = 1'b1;
        end else begin
          pc_d = pc_q;
          take = 1'b0;
        end
      end
      mtb_pkg::OP_NEXT_K: begin
        take = (k_q != LastSlot);
        if (k_q != LastSlot) begin
          k_d = k_q + 1'b1;
        end
      end
      mtb_pkg::OP_ANY: begin
        take = any_q;
      end
      default: begin
        take = 1'b1;
      end
    endcase
    if (take && uw.op != mtb_pkg::OP_DISPATCH) begin
      pc_d = uw.target;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= mtb_pkg::ST_IDLE;
      cur_q <= '0;
      k_q <= '0;
      any_q <= 1'b0;
      down_q <= '0;
      out_valid_q <= 1'b0;
      dev_q <= 3'd0;
      scale_x_q <= 18'd65536;
      scale_y_q <= 18'd65536;
      size_q <= 8'd0;
      for (int i = 0; i < mtb_pkg::SLOTS; i++) begin
        fx_q[i] <= 16'd0;
        fy_q[i] <= 16'd0;
      end
    end else begin
      pc_q <= pc_d;
      cur_q <= cur_d;
      k_q <= k_d;
      any_q <= any_d;
      down_q <= down_d;
      out_valid_q <= out_valid_d;
      if (pos_we) begin
        if (ev_q.ev_code == mtb_pkg::C_POS_X) begin
          fx_q[cur_q] <= pos_val;
        end else begin
          fy_q[cur_q] <= pos_val;
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mtb_pkg::REG_DEVICE_INDEX: dev_q <= cfg_wdata_i[2:0];
          mtb_pkg::REG_SCALE_X:      scale_x_q <= cfg_wdata_i;
          mtb_pkg::REG_SCALE_Y:      scale_y_q <= cfg_wdata_i;
          mtb_pkg::REG_TOUCH_SIZE:   size_q <= cfg_wdata_i[7:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ev_q <= ev_d;
    prod_q <= prod_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the multitouch slot-to-report bridge.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_EVENTS = 137;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           in_valid_i = 1'b0;
  logic                           in_ready_o;
  mtb_pkg::ev_in_t                in_data_i = '0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  mtb_pkg::ev_out_t               out_data_o;
  logic                           cfg_we_i = 1'b0;
  logic [mtb_pkg::CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [mtb_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatches = 0;
  int unsigned events_sent = 0;

  // shadow copy of the bridge state and registers
  logic [2:0]  dev_index_q;
  logic [17:0] scale_x_q;
  logic [17:0] scale_y_q;
  logic [7:0]  touch_size_q;
  logic [2:0]  slot_q;
  logic        down_q [mtb_pkg::SLOTS];
  logic [15:0] x_q [mtb_pkg::SLOTS];
  logic [15:0] y_q [mtb_pkg::SLOTS];

  mtb_pkg::ev_out_t pending_reports [$];

  multitouch_slot_to_report_bridge_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic mtb_pkg::ev_in_t mk_event(logic [15:0] ev_type, logic [15:0] ev_code,
                                               logic signed [31:0] ev_value);
    mtb_pkg::ev_in_t ev;
    ev.ev_type = ev_type;
    ev.ev_code = ev_code;
    ev.ev_value = ev_value;
    return ev;
  endfunction

  function automatic mtb_pkg::ev_out_t mk_report(logic [15:0] out_type,
                                                 logic [15:0] out_code,
                                                 logic [31:0] out_value, logic last);
    mtb_pkg::ev_out_t r;
    r.out_type = out_type;
    r.out_code = out_code;
    r.out_value = out_value;
    r.last = last;
    return r;
  endfunction

  function automatic void reset_shadow();
    dev_index_q = 3'd0;
    scale_x_q = 18'd65536;
    scale_y_q = 18'd65536;
    touch_size_q = 8'd0;
    slot_q = 3'd0;
    for (int k = 0; k < mtb_pkg::SLOTS; k++) begin
      down_q[k] = 1'b0;
      x_q[k] = 16'd0;
      y_q[k] = 16'd0;
    end
  endfunction

  function automatic logic [15:0] scaled_coord(logic signed [31:0] raw, logic [17:0] factor);
    logic [63:0] prod;
    if (raw <= 0) return 16'd0;
    prod = ({32'd0, raw} * {46'd0, factor}) >> 16;
    if (prod > 64'd65535) return 16'hffff;
    return prod[15:0];
  endfunction

  function automatic void predict_reports(mtb_pkg::ev_in_t ev);
    logic [2:0]  s;
    logic [31:0] track_id;
    bit          any_down;
    s = (slot_q >= mtb_pkg::SLOTS) ? 3'd0 : slot_q;
    any_down = 1'b0;
    if (ev.ev_type == mtb_pkg::TYPE_ABS) begin
      case (ev.ev_code)
        mtb_pkg::C_SLOT:
          if (ev.ev_value >= 0 && ev.ev_value < mtb_pkg::SLOTS) slot_q = ev.ev_value[2:0];
        mtb_pkg::C_TRACK_ID: down_q[s] = (ev.ev_value != -1);
        mtb_pkg::C_POS_X: x_q[s] = scaled_coord(ev.ev_value, scale_x_q);
        mtb_pkg::C_POS_Y: y_q[s] = scaled_coord(ev.ev_value, scale_y_q);
        default: ;
      endcase
      return;
    end
    if (ev.ev_type != mtb_pkg::TYPE_SYN || ev.ev_code != mtb_pkg::C_SYN_REPORT) return;
    for (int k = 0; k < mtb_pkg::SLOTS; k++) begin
      if (down_q[k]) begin
        any_down = 1'b1;
        track_id = (int'(dev_index_q) * 2 + 1) * 10 + k;
        pending_reports.push_back(mk_report(mtb_pkg::TYPE_ABS, mtb_pkg::C_ABS_X,
                                            {16'd0, x_q[k]}, 1'b0));
        pending_reports.push_back(mk_report(mtb_pkg::TYPE_ABS, mtb_pkg::C_ABS_Y,
                                            {16'd0, y_q[k]}, 1'b0));
        pending_reports.push_back(mk_report(mtb_pkg::TYPE_ABS, mtb_pkg::C_POS_X,
                                            {16'd0, x_q[k]}, 1'b0));
        pending_reports.push_back(mk_report(mtb_pkg::TYPE_ABS, mtb_pkg::C_POS_Y,
                                            {16'd0, y_q[k]}, 1'b0));
        pending_reports.push_back(mk_report(mtb_pkg::TYPE_ABS, mtb_pkg::C_TOUCH_MAJOR,
                                            {24'd0, touch_size_q}, 1'b0));
        pending_reports.push_back(mk_report(mtb_pkg::TYPE_ABS, mtb_pkg::C_WIDTH_MAJOR,
                                            {24'd0, touch_size_q}, 1'b0));
        pending_reports.push_back(mk_report(mtb_pkg::TYPE_ABS, mtb_pkg::C_TRACK_ID,
                                            track_id, 1'b0));
        pending_reports.push_back(mk_report(mtb_pkg::TYPE_SYN, mtb_pkg::C_SYN_MT_REPORT,
                                            32'd0, 1'b0));
      end
    end
    if (!any_down) begin
      pending_reports.push_back(mk_report(mtb_pkg::TYPE_SYN, mtb_pkg::C_SYN_MT_REPORT,
                                          32'd0, 1'b0));
    end
    pending_reports.push_back(mk_report(mtb_pkg::TYPE_SYN, mtb_pkg::C_SYN_REPORT,
                                        32'd0, 1'b1));
  endfunction

  // valid stays high across back-to-back transfers; wait_drained lowers it
  task automatic send_event(input mtb_pkg::ev_in_t ev);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= ev;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_reports(ev);
    events_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [2:0] dev, input logic [17:0] sx,
                              input logic [17:0] sy, input logic [7:0] size);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= mtb_pkg::REG_DEVICE_INDEX;
    cfg_wdata_i <= mtb_pkg::CFG_DATA_W'(dev);
    @(posedge clk_i);
    cfg_idx_i <= mtb_pkg::REG_SCALE_X;
    cfg_wdata_i <= sx;
    @(posedge clk_i);
    cfg_idx_i <= mtb_pkg::REG_SCALE_Y;
    cfg_wdata_i <= sy;
    @(posedge clk_i);
    cfg_idx_i <= mtb_pkg::REG_TOUCH_SIZE;
    cfg_wdata_i <= mtb_pkg::CFG_DATA_W'(size);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    dev_index_q = dev;
    scale_x_q = sx;
    scale_y_q = sy;
    touch_size_q = size;
  endtask

  function automatic logic signed [31:0] random_raw();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(0, 65535);
      2: return $urandom_range(0, 4095);
      3: return -$signed($urandom_range(1, 100));
      4: return 0;
      default: return $urandom_range(65536, 300000);
    endcase
  endfunction

  function automatic logic [17:0] random_scale();
    case ($urandom_range(5))
      0: return 18'd0;
      1: return 18'h3ffff;
      2: return 18'd65536;
      default: return 18'($urandom);
    endcase
  endfunction

  task automatic send_noise();
    case ($urandom_range(3))
      0: send_event(mk_event(16'($urandom), 16'($urandom), $urandom));
      1: send_event(mk_event(mtb_pkg::TYPE_SYN, 16'($urandom_range(1, 65535)), $urandom));
      2: send_event(mk_event(mtb_pkg::TYPE_ABS, 16'($urandom), $urandom));
      default: send_event(mk_event(mtb_pkg::TYPE_ABS, mtb_pkg::C_SLOT, $urandom));
    endcase
  endtask

  task automatic send_random_frame();
    int fingers;
    fingers = $urandom_range(0, mtb_pkg::SLOTS);
    for (int f = 0; f < fingers; f++) begin
      if ($urandom_range(9) == 0)
        send_event(mk_event(mtb_pkg::TYPE_ABS, mtb_pkg::C_SLOT,
                            $urandom_range(0, 1) ? -1 : $urandom_range(mtb_pkg::SLOTS, 7)));
      send_event(mk_event(mtb_pkg::TYPE_ABS, mtb_pkg::C_SLOT,
                          $urandom_range(0, mtb_pkg::SLOTS - 1)));
      case ($urandom_range(9))
        0, 1: send_event(mk_event(mtb_pkg::TYPE_ABS, mtb_pkg::C_TRACK_ID, -1));
        2: ;
        default: send_event(mk_event(mtb_pkg::TYPE_ABS, mtb_pkg::C_TRACK_ID, $urandom));
      endcase
      if ($urandom_range(3) != 0)
        send_event(mk_event(mtb_pkg::TYPE_ABS, mtb_pkg::C_POS_X, random_raw()));
      if ($urandom_range(3) != 0)
        send_event(mk_event(mtb_pkg::TYPE_ABS, mtb_pkg::C_POS_Y, random_raw()));
    end
    if ($urandom_range(9) == 0) send_noise();
    if ($urandom_range(7) != 0)
      send_event(mk_event(mtb_pkg::TYPE_SYN, mtb_pkg::C_SYN_REPORT, 0));
  endtask

  task automatic test_empty_sync();
    send_event(mk_event(mtb_pkg::TYPE_SYN, mtb_pkg::C_SYN_REPORT, 0));
    wait_drained();
  endtask

  task automatic test_position_extremes();
    send_event(mk_event(mtb_pkg::TYPE_ABS, mtb_pkg::C_TRACK_ID, 0));
    send_event(mk_event(mtb_pkg::TYPE_ABS, mtb_pkg::C_POS_X, 32'sh7fffffff));
    send_event(mk_event(mtb_pkg::TYPE_ABS, mtb_pkg::C_POS_Y, 32'sh80000000));
    send_event(mk_event(mtb_pkg::TYPE_ABS, mtb_pkg::C_SLOT, 1));
    send_event(mk_event(mtb_pkg::TYPE_ABS, mtb_pkg::C_TRACK_ID, 32'sh7fffffff));
    send_event(mk_event(mtb_pkg::TYPE_ABS, mtb_pkg::C_POS_X, 1));
    send_event(mk_event(mtb_pkg::TYPE_ABS, mtb_pkg::C_POS_Y, 65535));
    send_event(mk_event(mtb_pkg::TYPE_ABS, mtb_pkg::C_SLOT, 3));
    send_event(mk_event(mtb_pkg::TYPE_ABS, mtb_pkg::C_TRACK_ID, 32'sh80000000));
    send_event(mk_event(mtb_pkg::TYPE_ABS, mtb_pkg::C_POS_Y, -1));
    // coordinate stored in a slot whose finger is up
    send_event(mk_event(mtb_pkg::TYPE_ABS, mtb_pkg::C_SLOT, 2));
    send_event(mk_event(mtb_pkg::TYPE_ABS, mtb_pkg::C_POS_X, 100));
    send_event(mk_event(mtb_pkg::TYPE_SYN, mtb_pkg::C_SYN_REPORT, 0));
    wait_drained();
  endtask

  task automatic test_ignored_events();
    send_event(mk_event(mtb_pkg::TYPE_ABS, mtb_pkg::C_SLOT, -1));
    send_event(mk_event(mtb_pkg::TYPE_ABS, mtb_pkg::C_SLOT, mtb_pkg::SLOTS));
    send_event(mk_event(mtb_pkg::TYPE_ABS, mtb_pkg::C_SLOT, 32'sh7fffffff));
    send_event(mk_event(mtb_pkg::TYPE_ABS, mtb_pkg::C_SLOT, 32'sh80000000));
    send_event(mk_event(mtb_pkg::TYPE_ABS, mtb_pkg::C_TRACK_ID, -1));
    send_event(mk_event(16'hffff, mtb_pkg::C_SLOT, 0));
    send_event(mk_event(16'h0001, mtb_pkg::C_TRACK_ID, -1));
    send_event(mk_event(mtb_pkg::TYPE_SYN, 16'hffff, 0));
    send_event(mk_event(mtb_pkg::TYPE_ABS, 16'hffff, -1));
    send_event(mk_event(mtb_pkg::TYPE_ABS, mtb_pkg::C_ABS_X, 5));
    send_event(mk_event(mtb_pkg::TYPE_SYN, mtb_pkg::C_SYN_REPORT, 0));
    wait_drained();
  endtask

  task automatic test_config_extremes();
    write_config(3'd4, 18'd0, 18'h3ffff, 8'hff);
    for (int k = 0; k < mtb_pkg::SLOTS; k++) begin
      send_event(mk_event(mtb_pkg::TYPE_ABS, mtb_pkg::C_SLOT, k));
      send_event(mk_event(mtb_pkg::TYPE_ABS, mtb_pkg::C_TRACK_ID, k));
      send_event(mk_event(mtb_pkg::TYPE_ABS, mtb_pkg::C_POS_X, 32'sh7fffffff));
      send_event(mk_event(mtb_pkg::TYPE_ABS, mtb_pkg::C_POS_Y, 4000 * (k + 1)));
    end
    send_event(mk_event(mtb_pkg::TYPE_SYN, mtb_pkg::C_SYN_REPORT, 0));
    wait_drained();
    write_config(3'd3, 18'h3ffff, 18'd0, 8'd0);
    send_event(mk_event(mtb_pkg::TYPE_ABS, mtb_pkg::C_POS_X, 20000));
    send_event(mk_event(mtb_pkg::TYPE_ABS, mtb_pkg::C_POS_Y, 20000));
    send_event(mk_event(mtb_pkg::TYPE_SYN, mtb_pkg::C_SYN_REPORT, 0));
    wait_drained();
  endtask

  task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct);
    int unsigned start;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    write_config(3'($urandom_range(0, 4)), random_scale(), random_scale(),
                 8'($urandom_range(0, 255)));
    start = events_sent;
    while (events_sent - start < RANDOM_EVENTS) send_random_frame();
    send_event(mk_event(mtb_pkg::TYPE_SYN, mtb_pkg::C_SYN_REPORT, 0));
    wait_drained();
  endtask

  always @(posedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk_i) begin : check_reports
    mtb_pkg::ev_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected transfer: type %0h code %0h value %0d last %0b",
               out_data_o.out_type, out_data_o.out_code, out_data_o.out_value,
               out_data_o.last);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        if (out_data_o.out_type !== want.out_type) begin
          $error("out_type: expected %0h, actual %0h", want.out_type, out_data_o.out_type);
          mismatches++;
        end
        if (out_data_o.out_code !== want.out_code) begin
          $error("out_code: expected %0h, actual %0h", want.out_code, out_data_o.out_code);
          mismatches++;
        end
        if (out_data_o.out_value !== want.out_value) begin
          $error("out_value: expected %0d, actual %0d", want.out_value, out_data_o.out_value);
          mismatches++;
        end
        if (out_data_o.last !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, out_data_o.last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    reset_shadow();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 37;
    recv_idle_pct = 65;
    test_empty_sync();
    test_position_extremes();
    test_ignored_events();
    test_config_extremes();
    test_random_traffic(37, 65);
    test_random_traffic(65, 37);
    test_random_traffic(0, 0);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
